### rtl/core/log_bucket_latency_histogram_macros.svh
// Assertion macros for the latency histogram.
// Used by the top level only.
`ifndef LOG_BUCKET_LATENCY_HISTOGRAM_MACROS_SVH
`define LOG_BUCKET_LATENCY_HISTOGRAM_MACROS_SVH
`define LBH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/core/lbh_pkg.sv
// Shared types and constants for the latency histogram.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lbh_pkg;
    localparam int SECONDS_DIGITS = 7;
    localparam int MAX_BOUNDS = 43;
    localparam int CLASS_ROWS = 3;
    localparam logic [9:0] BASE_RESET = 10'd10;
    localparam logic [63:0] ONE_SECOND_US = 64'd1000000;

    localparam logic [1:0] CMD_COLLECT = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_build;
        logic start_clear;
        logic do_lookup;
        logic do_update;
        logic do_read;
        logic do_result;
    } t_dp_cmd;

    typedef struct packed {
        logic build_done;
        logic clear_done;
        logic base_changed;
    } t_dp_status;
endpackage
`default_nettype wire

### rtl/core/lbh_ctrl.sv
// Controller state machine of the latency histogram.
// Depends on lbh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbh_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_command,
    input  wire logic               i_out_busy,
    input  wire lbh_pkg::t_dp_status i_status,
    output lbh_pkg::t_dp_cmd        o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_LOOKUP, S_UPDATE, S_READ, S_RESULT, S_BUILD, S_CLEAR
    } t_state;

    t_state r_state;
    t_state n_state;
    lbh_pkg::t_dp_cmd n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_command)
                        lbh_pkg::CMD_COLLECT: begin
                            n_state = S_LOOKUP;
                            n_cmd.do_lookup = 1'b1;
                        end
                        lbh_pkg::CMD_FLUSH: begin
                            if (i_status.base_changed) begin
                                n_state = S_BUILD;
                                n_cmd.start_build = 1'b1;
                            end else begin
                                n_state = S_CLEAR;
                                n_cmd.start_clear = 1'b1;
                            end
                        end
                        lbh_pkg::CMD_READ: begin
                            n_state = S_READ;
                            n_cmd.do_read = 1'b1;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP: begin
                n_state = S_UPDATE;
                n_cmd.do_update = 1'b1;
            end
            S_UPDATE: n_state = S_IDLE;
            S_READ: n_state = S_RESULT;
            S_RESULT: begin
                if (!i_out_busy) begin
                    n_state = S_IDLE;
                    n_cmd.do_result = 1'b1;
                end
            end
            S_BUILD: begin
                if (i_status.build_done) begin
                    n_state = S_CLEAR;
                    n_cmd.start_clear = 1'b1;
                end
            end
            S_CLEAR: begin
                if (i_status.clear_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_cmd <= '0;
        end else begin
            r_state <= n_state;
            o_cmd <= n_cmd;
        end
    end

    assign o_stall = (r_state != S_IDLE);
endmodule
`default_nettype wire

### rtl/core/lbh_datapath.sv
// Datapath of the latency histogram: bound table, builder, counters.
// Depends on lbh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbh_datapath #(
    parameter int SECONDS_DIGITS = lbh_pkg::SECONDS_DIGITS,
    parameter int MAX_BOUNDS = lbh_pkg::MAX_BOUNDS,
    parameter int CLASS_ROWS = lbh_pkg::CLASS_ROWS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lbh_pkg::t_dp_cmd   i_cmd,
    output lbh_pkg::t_dp_status     o_status,
    input  wire logic [9:0]         i_range_base,
    input  wire logic [1:0]         i_query_class,
    input  wire logic [63:0]        i_response_time,
    input  wire logic [5:0]         i_bucket_index,
    input  wire logic               i_capture,
    output logic [63:0]             o_bucket_bound,
    output logic [31:0]             o_bucket_count,
    output logic [63:0]             o_bucket_total,
    output logic                    o_is_overflow,
    output logic                    o_index_valid
);
    localparam int ROW_LEN = MAX_BOUNDS + 1;
    localparam int DEPTH = CLASS_ROWS * ROW_LEN;
    localparam int AW = $clog2(DEPTH);
    localparam int BW = $clog2(MAX_BOUNDS + 1);
    localparam int CW = (CLASS_ROWS > 1) ? $clog2(CLASS_ROWS) : 1;

    function automatic logic [63:0] f_limit();
        logic [63:0] v;
        v = lbh_pkg::ONE_SECOND_US;
        for (int k = 0; k < SECONDS_DIGITS; k++) v = v * 64'd10;
        return v;
    endfunction
    localparam logic [63:0] LIMIT = f_limit();

    typedef enum logic [2:0] {
        B_IDLE, B_DIV, B_DIVSTEP, B_MUL, B_FILL, B_DONE
    } t_bstate;

    logic [63:0] r_bound [MAX_BOUNDS];
    logic [BW-1:0] r_count;
    logic [9:0] r_active_base;
    logic [MAX_BOUNDS-1:0] r_loaded;

    // Bound builder: sequential divider and multiplier over the table.
    t_bstate r_bstate;
    logic [9:0] r_base;
    logic [19:0] r_quot;
    logic [19:0] r_rem;
    logic [4:0] r_dbit;
    logic [19:0] r_dividend;
    logic [BW-1:0] r_neg;
    logic [19:0] r_sub [MAX_BOUNDS];
    logic [63:0] r_mval;
    logic [BW-1:0] r_n;
    logic r_build_done;

    logic [20:0] n_rem;
    logic [9:0] w_base_eff;
    assign w_base_eff = (i_range_base < 10'd2) ? 10'd2 : i_range_base;
    assign n_rem = {r_rem, r_dividend[r_dbit]};

    // Default table for base 10.
    function automatic logic [63:0] f_default(input int k);
        logic [63:0] v;
        int neg;
        int j;
        v = lbh_pkg::ONE_SECOND_US;
        neg = 6;
        if (neg > MAX_BOUNDS) neg = MAX_BOUNDS;
        if (k < neg) begin
            v = lbh_pkg::ONE_SECOND_US;
            for (j = 0; j < 6; j++) if (j < neg - k) v = v / 64'd10;
        end else begin
            for (j = 0; j < 64; j++) if (j < k - neg) v = v * 64'd10;
            if (v >= LIMIT || k - neg > 19) v = 64'd0;
        end
        return v;
    endfunction
    function automatic int f_default_count();
        int n;
        logic [63:0] v;
        n = (6 > MAX_BOUNDS) ? MAX_BOUNDS : 6;
        v = lbh_pkg::ONE_SECOND_US;
        for (int j = 0; j < 64; j++) begin
            if (v < LIMIT && n < MAX_BOUNDS) begin
                n = n + 1;
                v = v * 64'd10;
            end
        end
        return n;
    endfunction
    localparam int DEF_COUNT = f_default_count();

    logic [63:0] w_bound [MAX_BOUNDS];
    for (genvar g = 0; g < MAX_BOUNDS; g++) begin : g_bound
        localparam logic [63:0] DEF = f_default(g);
        assign w_bound[g] = r_loaded[g] ? r_bound[g] : DEF;
    end

    logic [63:0] w_prod;
    assign w_prod = r_mval[53:0] * {54'd0, r_base};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate <= B_IDLE;
            r_build_done <= 1'b0;
            r_loaded <= '0;
            r_count <= BW'(DEF_COUNT);
            r_active_base <= lbh_pkg::BASE_RESET;
        end else begin
            r_build_done <= (r_bstate == B_DONE);
            case (r_bstate)
                B_IDLE: begin
                    if (i_cmd.start_build) begin
                        r_base <= w_base_eff;
                        r_active_base <= i_range_base;
                        r_dividend <= 20'd1000000;
                        r_neg <= '0;
                        r_bstate <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_rem <= '0;
                    r_quot <= '0;
                    r_dbit <= 5'd19;
                    r_bstate <= B_DIVSTEP;
                end
                B_DIVSTEP: begin
                    if (n_rem >= {11'd0, r_base}) begin
                        r_rem <= 20'(n_rem - {11'd0, r_base});
                        r_quot <= {r_quot[18:0], 1'b1};
                    end else begin
                        r_rem <= n_rem[19:0];
                        r_quot <= {r_quot[18:0], 1'b0};
                    end
                    if (r_dbit == 5'd0) begin
                        r_bstate <= B_MUL;
                    end else begin
                        r_dbit <= r_dbit - 5'd1;
                    end
                end
                B_MUL: begin
                    // A fresh quotient sits in r_quot; keep it when nonzero.
                    if (r_quot != 20'd0 && 32'(r_neg) < MAX_BOUNDS) begin
                        r_sub[r_neg] <= r_quot;
                        r_neg <= r_neg + BW'(1);
                        r_dividend <= r_quot;
                        r_bstate <= B_DIV;
                    end else begin
                        r_n <= '0;
                        r_mval <= lbh_pkg::ONE_SECOND_US;
                        r_bstate <= B_FILL;
                    end
                end
                B_FILL: begin
                    if (32'(r_n) < MAX_BOUNDS) begin
                        r_loaded[r_n] <= 1'b1;
                        if (r_n < r_neg) begin
                            r_bound[r_n] <= {44'd0, r_sub[r_neg - r_n - BW'(1)]};
                        end else if (r_mval < LIMIT && r_mval != 64'd0) begin
                            r_bound[r_n] <= r_mval;
                            r_mval <= (r_mval[63:54] != 10'd0) ? 64'd0 : w_prod;
                            r_count <= r_n + BW'(1);
                        end else begin
                            r_bound[r_n] <= 64'd0;
                            r_mval <= 64'd0;
                        end
                        if (r_n < r_neg) r_count <= r_n + BW'(1);
                        r_n <= r_n + BW'(1);
                    end else begin
                        r_bstate <= B_DONE;
                    end
                end
                B_DONE: begin
                    r_bstate <= B_IDLE;
                end
                default: r_bstate <= B_IDLE;
            endcase
        end
    end

    // Counter memories with a clearing pass.
    logic [31:0] r_hits [DEPTH];
    logic [63:0] r_tot [DEPTH];
    logic r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic r_clear_done;

    logic r_second;
    logic [AW-1:0] r_addr0;
    logic [AW-1:0] r_addr1;
    logic [31:0] r_rd_hits;
    logic [63:0] r_rd_tot;
    logic [31:0] r_rd_hits1;
    logic [63:0] r_rd_tot1;

    logic [BW-1:0] w_bucket;
    always_comb begin
        w_bucket = r_count;
        for (int k = MAX_BOUNDS - 1; k >= 0; k--) begin
            if (32'(k) < 32'(r_count) && w_bound[k] > i_response_time) w_bucket = BW'(k);
        end
    end

    logic w_cls_ok;
    assign w_cls_ok = 32'(i_query_class) < CLASS_ROWS;
    logic [AW-1:0] w_cls_base;
    assign w_cls_base = AW'(32'(i_query_class[CW-1:0]) * ROW_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_clear_done <= 1'b0;
        end else begin
            r_clear_done <= !i_cmd.start_clear && r_clearing
                && (32'(r_clr_addr) == DEPTH - 1);
            if (i_cmd.start_clear) begin
                r_clearing <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clearing) begin
                if (32'(r_clr_addr) == DEPTH - 1) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_hits[r_clr_addr] <= '0;
            r_tot[r_clr_addr] <= '0;
        end else if (i_cmd.do_lookup) begin
            r_addr0 <= AW'(w_bucket);
            r_addr1 <= AW'(w_cls_base + AW'(w_bucket));
            r_second <= (i_query_class != 2'd0) && w_cls_ok;
            r_rd_hits <= r_hits[AW'(w_bucket)];
            r_rd_tot <= r_tot[AW'(w_bucket)];
            r_rd_hits1 <= r_hits[AW'(w_cls_base + AW'(w_bucket))];
            r_rd_tot1 <= r_tot[AW'(w_cls_base + AW'(w_bucket))];
        end else if (i_cmd.do_update) begin
            r_hits[r_addr0] <= r_rd_hits + 32'd1;
            r_tot[r_addr0] <= r_rd_tot + i_response_time;
            if (r_second) begin
                r_hits[r_addr1] <= r_rd_hits1 + 32'd1;
                r_tot[r_addr1] <= r_rd_tot1 + i_response_time;
            end
        end else if (i_cmd.do_read) begin
            r_rd_hits <= r_hits[AW'(w_cls_base + AW'(i_bucket_index))];
            r_rd_tot <= r_tot[AW'(w_cls_base + AW'(i_bucket_index))];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            if (i_bucket_index <= 6'(r_count)) begin
                o_index_valid <= 1'b1;
                o_is_overflow <= (i_bucket_index == 6'(r_count));
                o_bucket_bound <= (i_bucket_index == 6'(r_count)) ? 64'd0
                    : w_bound[i_bucket_index[BW-1:0]];
                o_bucket_count <= w_cls_ok ? r_rd_hits : 32'd0;
                o_bucket_total <= w_cls_ok ? r_rd_tot : 64'd0;
            end else begin
                o_index_valid <= 1'b0;
                o_is_overflow <= 1'b0;
                o_bucket_bound <= '0;
                o_bucket_count <= '0;
                o_bucket_total <= '0;
            end
        end
    end

    assign o_status.build_done = r_build_done;
    assign o_status.clear_done = r_clear_done;
    assign o_status.base_changed = (i_range_base != r_active_base);
endmodule
`default_nettype wire

### rtl/core/log_bucket_latency_histogram.sv
// Top level of the latency histogram: input register, controller, datapath.
// Depends on lbh_pkg, lbh_ctrl, lbh_datapath and the macros header.
//
// Channel | Direction | Handshake
// input   | in        | i_valid / o_stall
// output  | out       | o_valid / i_stall
// config  | in        | i_cfg_we / i_cfg_wdata
//
// A collect compares against all bounds, then updates the counters.
// A read fetches the counters, then waits while the output is stalled before
// its result is registered. A flush clears CLASS_ROWS*(MAX_BOUNDS+1) entries, one
// per cycle; a base change first runs a bit-serial divider (one more division
// than sub-second bounds) and a table fill over all MAX_BOUNDS entries. After
// reset the same clearing pass runs while input is stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "log_bucket_latency_histogram_macros.svh"
module log_bucket_latency_histogram #(
    parameter int SECONDS_DIGITS = lbh_pkg::SECONDS_DIGITS,
    parameter int MAX_BOUNDS = lbh_pkg::MAX_BOUNDS,
    parameter int CLASS_ROWS = lbh_pkg::CLASS_ROWS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [1:0]  i_query_class,
    input  wire logic [63:0] i_response_time,
    input  wire logic [5:0]  i_bucket_index,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_bucket_bound,
    output logic [31:0]      o_bucket_count,
    output logic [63:0]      o_bucket_total,
    output logic             o_is_overflow,
    output logic             o_index_valid,
    input  wire logic        i_cfg_we,
    input  wire logic [9:0]  i_cfg_wdata
);
    logic [9:0] r_range_base;
    logic [1:0] r_query_class;
    logic [63:0] r_response_time;
    logic [5:0] r_bucket_index;
    logic r_valid;
    logic w_accept;
    logic w_ctrl_stall;
    lbh_pkg::t_dp_cmd w_cmd;
    lbh_pkg::t_dp_status w_status;

    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_base <= lbh_pkg::BASE_RESET;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_range_base <= i_cfg_wdata;
            if (w_cmd.do_result) r_valid <= 1'b1;
            else if (r_valid && !i_stall) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query_class <= i_query_class;
            r_response_time <= i_response_time;
            r_bucket_index <= i_bucket_index;
        end
    end

    lbh_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_accept),
        .o_stall(w_ctrl_stall),
        .i_command(i_command),
        .i_out_busy(r_valid && i_stall),
        .i_status(w_status),
        .o_cmd(w_cmd)
    );

    // Commands are registered along with the controller state, so the datapath sees
    // them as the controller enters its next state; the stall covers them too.
    logic w_dp_busy;
    assign w_dp_busy = w_cmd.start_build || w_cmd.start_clear || w_cmd.do_lookup
        || w_cmd.do_update || w_cmd.do_read || w_cmd.do_result;
    logic r_clr_busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_busy <= 1'b1;
        else if (w_status.clear_done) r_clr_busy <= 1'b0;
        else if (w_cmd.start_clear) r_clr_busy <= 1'b1;
    end
    assign o_stall = w_ctrl_stall || w_dp_busy || r_clr_busy;

    lbh_datapath #(
        .SECONDS_DIGITS(SECONDS_DIGITS),
        .MAX_BOUNDS(MAX_BOUNDS),
        .CLASS_ROWS(CLASS_ROWS)
    ) u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(w_cmd),
        .o_status(w_status),
        .i_range_base(r_range_base),
        .i_query_class(w_accept ? i_query_class : r_query_class),
        .i_response_time(r_response_time),
        .i_bucket_index(r_bucket_index),
        .i_capture(w_cmd.do_result),
        .o_bucket_bound(o_bucket_bound),
        .o_bucket_count(o_bucket_count),
        .o_bucket_total(o_bucket_total),
        .o_is_overflow(o_is_overflow),
        .o_index_valid(o_index_valid)
    );

    assign o_valid = r_valid;

    `LBH_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_clr_busy, !w_accept)
    `LBH_ASSERT_NEXT(a_result_valid, i_clk, i_rst_n, w_cmd.do_result, o_valid)
    `LBH_ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({w_cmd.do_lookup, w_cmd.do_update, w_cmd.do_read, w_cmd.do_result}))
endmodule
`default_nettype wire

### test/log_bucket_latency_histogram_tb.sv
// Self-checking testbench for the logarithmic latency histogram.
// It predicts every bucket read from its own model of the bounds and counters.
// Depends on lbh_pkg and the log_bucket_latency_histogram RTL.
`timescale 1ns / 1ps
module log_bucket_latency_histogram_tb;
    localparam int ROW_LEN = lbh_pkg::MAX_BOUNDS + 1;
    localparam int SETTLE_CYCLES = 1200;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [63:0] bound;
        logic [31:0] count;
        logic [63:0] total;
        logic        ovf;
        logic        valid;
    } t_bucket_read;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = lbh_pkg::CMD_COLLECT;
    logic [1:0]  i_query_class = 2'd0;
    logic [63:0] i_response_time = 64'd0;
    logic [5:0]  i_bucket_index = 6'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_bucket_bound;
    logic [31:0] o_bucket_count;
    logic [63:0] o_bucket_total;
    logic        o_is_overflow;
    logic        o_index_valid;
    logic        i_cfg_we = 1'b0;
    logic [9:0]  i_cfg_wdata = 10'd0;

    log_bucket_latency_histogram DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_query_class(i_query_class),
        .i_response_time(i_response_time), .i_bucket_index(i_bucket_index),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_bucket_bound(o_bucket_bound), .o_bucket_count(o_bucket_count),
        .o_bucket_total(o_bucket_total), .o_is_overflow(o_is_overflow),
        .o_index_valid(o_index_valid),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Histogram model state.
    logic [9:0]  cfg_base;
    logic [9:0]  cur_base;
    logic [63:0] bounds [lbh_pkg::MAX_BOUNDS];
    int          num_bounds;
    logic [31:0] hits [lbh_pkg::CLASS_ROWS][ROW_LEN];
    logic [63:0] sums [lbh_pkg::CLASS_ROWS][ROW_LEN];

    t_bucket_read pending_reads [$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  cycles = 0;
    bit  failed = 1'b0;

    function automatic void rebuild_bounds(logic [9:0] base_raw);
        logic [63:0] b;
        logic [63:0] v;
        logic [63:0] limit;
        int neg;
        int n;
        b = (base_raw < 10'd2) ? 64'd2 : 64'(base_raw);
        limit = lbh_pkg::ONE_SECOND_US;
        neg = 0;
        for (int i = 0; i < lbh_pkg::SECONDS_DIGITS; i++) limit = limit * 10;
        v = lbh_pkg::ONE_SECOND_US / b;
        while (v > 0) begin
            neg++;
            v = v / b;
        end
        if (neg > lbh_pkg::MAX_BOUNDS) neg = lbh_pkg::MAX_BOUNDS;
        v = lbh_pkg::ONE_SECOND_US;
        for (int i = 0; i < neg; i++) begin
            v = v / b;
            bounds[neg - 1 - i] = v;
        end
        n = neg;
        v = lbh_pkg::ONE_SECOND_US;
        while (v < limit && n < lbh_pkg::MAX_BOUNDS) begin
            bounds[n] = v;
            n++;
            v = v * b;
        end
        for (int i = n; i < lbh_pkg::MAX_BOUNDS; i++) bounds[i] = 64'd0;
        num_bounds = n;
    endfunction

    function automatic void clear_histogram();
        for (int r = 0; r < lbh_pkg::CLASS_ROWS; r++) begin
            for (int k = 0; k < ROW_LEN; k++) begin
                hits[r][k] = 32'd0;
                sums[r][k] = 64'd0;
            end
        end
    endfunction

    function automatic void account_request(logic [1:0] cmd, logic [1:0] cls,
                                            logic [63:0] t, logic [5:0] idx);
        int bucket;
        t_bucket_read rd;
        if (cmd == lbh_pkg::CMD_COLLECT) begin
            bucket = num_bounds;
            for (int i = num_bounds - 1; i >= 0; i--) begin
                if (bounds[i] > t) bucket = i;
            end
            hits[0][bucket] += 32'd1;
            sums[0][bucket] += t;
            if (cls != 2'd0 && cls < lbh_pkg::CLASS_ROWS) begin
                hits[cls][bucket] += 32'd1;
                sums[cls][bucket] += t;
            end
        end else if (cmd == lbh_pkg::CMD_FLUSH) begin
            if (cfg_base != cur_base) begin
                cur_base = cfg_base;
                rebuild_bounds(cur_base);
            end
            clear_histogram();
        end else if (cmd == lbh_pkg::CMD_READ) begin
            rd = '0;
            if (idx <= num_bounds) begin
                rd.valid = 1'b1;
                if (idx == num_bounds) rd.ovf = 1'b1;
                else rd.bound = bounds[idx];
                if (cls < lbh_pkg::CLASS_ROWS) begin
                    rd.count = hits[cls][idx];
                    rd.total = sums[cls][idx];
                end
            end
            pending_reads.push_back(rd);
        end
    endfunction

    // Sends one request; returns at the falling edge after acceptance with valid still high.
    task automatic send_request(logic [1:0] cmd, logic [1:0] cls,
                                logic [63:0] t, logic [5:0] idx);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_command = cmd;
        i_query_class = cls;
        i_response_time = t;
        i_bucket_index = idx;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        account_request(cmd, cls, t, idx);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid = 1'b0;
        while (pending_reads.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_base(logic [9:0] value);
        wait_idle();
        i_cfg_wdata = value;
        i_cfg_we = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cfg_base = value;
    endtask

    function automatic logic [63:0] pick_time();
        int k;
        k = $urandom_range(num_bounds - 1);
        case ($urandom_range(7))
            0: return 64'd0;
            1: return {$urandom, $urandom};
            2: return 64'hFFFF_FFFF_FFFF_FFFF;
            3: return bounds[k] - 64'd1;
            4: return bounds[k];
            5: return bounds[k] + 64'd1;
            default: return bounds[k] + 64'($urandom_range(1000));
        endcase
    endfunction

    function automatic logic [5:0] pick_index();
        if ($urandom_range(9) == 0) return 6'($urandom_range(63));
        return 6'($urandom_range(num_bounds + 1));
    endfunction

    task automatic test_reset_contents();
        send_request(lbh_pkg::CMD_READ, 2'd0, 64'd0, 6'd0);
        send_request(lbh_pkg::CMD_READ, 2'd2, 64'd0, 6'(num_bounds - 1));
        send_request(lbh_pkg::CMD_READ, 2'd1, 64'd0, 6'(num_bounds));
        send_request(lbh_pkg::CMD_READ, 2'd0, 64'd0, 6'(num_bounds + 1));
        send_request(lbh_pkg::CMD_READ, 2'd0, 64'd0, 6'd63);
    endtask

    task automatic test_collect_edges();
        send_request(lbh_pkg::CMD_COLLECT, 2'd0, 64'd0, 6'd0);
        send_request(lbh_pkg::CMD_COLLECT, 2'd1, bounds[0], 6'd0);
        send_request(lbh_pkg::CMD_COLLECT, 2'd2, bounds[0] - 64'd1, 6'd63);
        send_request(lbh_pkg::CMD_COLLECT, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
        send_request(lbh_pkg::CMD_COLLECT, 2'd2, bounds[num_bounds - 1], 6'd0);
        send_request(lbh_pkg::CMD_COLLECT, 2'd1, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
        send_request(CMD_UNUSED, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
        for (int c = 0; c < 4; c++) begin
            send_request(lbh_pkg::CMD_READ, 2'(c), 64'd0, 6'd0);
            send_request(lbh_pkg::CMD_READ, 2'(c), 64'd0, 6'(num_bounds));
        end
        send_request(lbh_pkg::CMD_READ, 2'd1, 64'd0, 6'd1);
        send_request(lbh_pkg::CMD_FLUSH, 2'd0, 64'd0, 6'd0);
        send_request(lbh_pkg::CMD_READ, 2'd0, 64'd0, 6'(num_bounds));
    endtask

    task automatic test_random_traffic(logic [9:0] base, int idle_pct, int stall_pct,
                                       int count);
        int sel;
        write_base(base);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        send_request(lbh_pkg::CMD_FLUSH, 2'($urandom_range(3)), {$urandom, $urandom},
                     6'($urandom));
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 52)
                send_request(lbh_pkg::CMD_COLLECT, 2'($urandom_range(3)), pick_time(),
                             6'($urandom));
            else if (sel < 96)
                send_request(lbh_pkg::CMD_READ, 2'($urandom_range(3)), {$urandom, $urandom},
                             pick_index());
            else if (sel < 98)
                send_request(CMD_UNUSED, 2'($urandom_range(3)), {$urandom, $urandom},
                             6'($urandom));
            else
                send_request(lbh_pkg::CMD_FLUSH, 2'($urandom_range(3)), {$urandom, $urandom},
                             6'($urandom));
        end
        // A base change with no flush after it must not move the bounds.
        if ($urandom_range(1)) write_base(10'($urandom_range(1023)));
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_bucket_read exp_rd;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_reads.size() == 0) begin
                $error("bucket read returned with no request outstanding");
                failed = 1'b1;
            end else begin
                exp_rd = pending_reads.pop_front();
                if (o_bucket_bound !== exp_rd.bound) begin
                    $error("bucket_bound expected %0d got %0d", exp_rd.bound, o_bucket_bound);
                    failed = 1'b1;
                end
                if (o_bucket_count !== exp_rd.count) begin
                    $error("bucket_count expected %0d got %0d", exp_rd.count, o_bucket_count);
                    failed = 1'b1;
                end
                if (o_bucket_total !== exp_rd.total) begin
                    $error("bucket_total expected %0d got %0d", exp_rd.total, o_bucket_total);
                    failed = 1'b1;
                end
                if (o_is_overflow !== exp_rd.ovf) begin
                    $error("is_overflow expected %0b got %0b", exp_rd.ovf, o_is_overflow);
                    failed = 1'b1;
                end
                if (o_index_valid !== exp_rd.valid) begin
                    $error("index_valid expected %0b got %0b", exp_rd.valid, o_index_valid);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        cfg_base = lbh_pkg::BASE_RESET;
        cur_base = lbh_pkg::BASE_RESET;
        rebuild_bounds(lbh_pkg::BASE_RESET);
        clear_histogram();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_contents();
        test_collect_edges();
        test_random_traffic(10'd2, 0, 0, 220);
        test_random_traffic(10'd1000, 45, 0, 220);
        test_random_traffic(10'd3, 0, 45, 220);
        test_random_traffic(10'd0, 7, 7, 200);
        test_random_traffic(10'd1023, 0, 0, 200);
        test_random_traffic(10'd1, 45, 0, 150);
        test_random_traffic(10'd10, 0, 45, 250);
        test_random_traffic(10'($urandom_range(4, 999)), 7, 7, 260);

        wait_idle();
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
